/* src/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/lapsa_pkg.sv */
// types, constants and helpers of the laplacian stencil accumulator
`timescale 1ns / 1ps
package lapsa_pkg;

	localparam int unsigned MAX_COLUMNS_DEF = 1024;
	localparam int unsigned MAX_ROWS_DEF    = 1024;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned SCALE_W     = 16;
	localparam int unsigned GEOM_W      = 11;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned MIN_GEOM    = 2;

	// stencil sum, product with scale, q16.16 after the shift, difference
	localparam int unsigned LAP_W   = 36;
	localparam int unsigned PROD_W  = LAP_W + SCALE_W;
	localparam int unsigned FRAC_SH = 8;
	localparam int unsigned SH_W    = PROD_W - FRAC_SH;
	localparam int unsigned DIFF_W  = SH_W + 1;

	localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd256;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROW_COUNT,
		REG_COLUMN_COUNT,
		REG_SCALE
	} cfg_reg_t;

	typedef enum logic {
		OP_PUSH,
		OP_DRAIN
	} opcode_t;

	typedef struct packed {
		opcode_t                  opcode;
		logic signed [DATA_W-1:0] grid_value;
		logic signed [DATA_W-1:0] accum_value;
	} request_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic                     end_of_frame;
		logic                     saturated;
	} result_t;

	// one column of the line store: newest row, row above it, accumulator of newest row
	typedef struct packed {
		logic signed [DATA_W-1:0] x_cur;
		logic signed [DATA_W-1:0] x_prev;
		logic signed [DATA_W-1:0] accum;
	} line_entry_t;

	function automatic logic signed [LAP_W-1:0] lap_term(
		input logic signed [DATA_W-1:0] center,
		input logic signed [DATA_W-1:0] nb,
		input logic                     present
	);
		logic signed [LAP_W-1:0] diff;
		diff = LAP_W'(center) - LAP_W'(nb);
		return present ? diff : '0;
	endfunction

endpackage

/* src/lapsa_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module lapsa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/laplacian_stencil_accumulate_top.sv */
// top level of the streaming five-point laplacian accumulator
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------------
//  request  | request_valid / request_ready | request  (opcode, grid, accum)
//  result   | result_valid / result_ready   | result   (value, eof, saturated)
//  config   | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// one request per cycle unless stalled; each live request reads the line store
// entry of the next column at acceptance, and that single read port sets the rate
// a result passes the stage registers in order: line store read, stencil sum,
// multiply, shift and saturate into the output register
// no clearing pass after reset: the line store is filled by the first row of a frame
// with result_ready low the stage registers fill, then request_ready drops
`timescale 1ns / 1ps
`include "assert_macros.svh"
module laplacian_stencil_accumulate_top #(
	parameter int unsigned MAX_COLUMNS = lapsa_pkg::MAX_COLUMNS_DEF,
	parameter int unsigned MAX_ROWS    = lapsa_pkg::MAX_ROWS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lapsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lapsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               request_valid,
	output logic                               request_ready,
	input  lapsa_pkg::request_t                request,
	output logic                               result_valid,
	input  logic                               result_ready,
	output lapsa_pkg::result_t                 result
);
	import lapsa_pkg::*;

	localparam int unsigned AddrW = $clog2(MAX_COLUMNS);
	localparam int unsigned ColW  = $clog2(MAX_COLUMNS + 1);
	localparam int unsigned RowW  = $clog2(MAX_ROWS + 1);

	typedef struct packed {
		logic                     emit;
		logic                     write;
		logic                     has_up;
		logic                     has_left;
		logic                     has_right;
		logic                     eof;
		logic [AddrW-1:0]         col;
		logic signed [DATA_W-1:0] x_in;
		logic signed [DATA_W-1:0] a_in;
	} op_t;

	// configuration
	logic [RowW-1:0]           rows_q;
	logic [ColW-1:0]           cols_q;
	logic signed [SCALE_W-1:0] scale_q;
	logic [GEOM_W-1:0]         geom_wr;
	logic [RowW-1:0]           rows_wr;
	logic [ColW-1:0]           cols_wr;

	// position counters
	logic [RowW-1:0]  in_row_q;
	logic [AddrW-1:0] in_col_q;
	logic [RowW-1:0]  out_row_q;
	logic [AddrW-1:0] out_col_q;

	// request decode
	logic             accept;
	logic             is_push;
	logic             frame_in_done;
	logic             op_live;
	logic [AddrW-1:0] op_col;
	logic [ColW-1:0]  col_ext;
	logic             last_col;
	logic [AddrW-1:0] rd_addr;
	op_t              op_new;

	// stage 1: line store data
	logic        v1_q;
	op_t         op_s1;
	logic        fwd_s1;
	line_entry_t fwd_data_s1;
	line_entry_t cur_q;
	logic signed [DATA_W-1:0] left_q;
	line_entry_t nxt_entry;
	line_entry_t wr_entry;
	logic [$bits(line_entry_t)-1:0] ram_rdata;
	logic        ram_we;
	logic signed [LAP_W-1:0] lap_w;
	logic        s1_go;

	// stage 2 and 3, output register
	logic                      v2_q;
	logic signed [LAP_W-1:0]   lap_s2;
	logic signed [DATA_W-1:0]  acc_s2;
	logic                      eof_s2;
	logic                      v3_q;
	logic signed [PROD_W-1:0]  prod_s3;
	logic signed [DATA_W-1:0]  acc_s3;
	logic                      eof_s3;
	logic signed [PROD_W-1:0]  prod_w;
	logic signed [SH_W-1:0]    sh_w;
	logic signed [DIFF_W-1:0]  diff_w;
	logic                      sat_hi;
	logic                      sat_lo;
	result_t                   res_w;
	logic                      result_valid_q;
	result_t                   result_q;
	logic                      rdy_o;
	logic                      rdy3;
	logic                      rdy2;

	// configuration port, geometry kept clamped
	assign cfg_ready = 1'b1;
	assign geom_wr   = cfg_data[GEOM_W-1:0];

	always_comb begin
		if (int'(geom_wr) < int'(MIN_GEOM)) begin
			rows_wr = RowW'(MIN_GEOM);
		end else if (int'(geom_wr) > int'(MAX_ROWS)) begin
			rows_wr = RowW'(MAX_ROWS);
		end else begin
			rows_wr = RowW'(geom_wr);
		end
		if (int'(geom_wr) < int'(MIN_GEOM)) begin
			cols_wr = ColW'(MIN_GEOM);
		end else if (int'(geom_wr) > int'(MAX_COLUMNS)) begin
			cols_wr = ColW'(MAX_COLUMNS);
		end else begin
			cols_wr = ColW'(geom_wr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= RowW'(MIN_GEOM);
			cols_q  <= ColW'(MIN_GEOM);
			scale_q <= SCALE_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_COUNT:    rows_q  <= rows_wr;
				REG_COLUMN_COUNT: cols_q  <= cols_wr;
				REG_SCALE:        scale_q <= signed'(cfg_data[SCALE_W-1:0]);
				default: ;
			endcase
		end
	end

	// request decode; pushes past the frame and early drains are dropped
	assign accept        = request_valid && request_ready;
	assign is_push       = (request.opcode == OP_PUSH);
	assign frame_in_done = (in_row_q >= rows_q);
	assign op_live       = accept && (is_push ? !frame_in_done : frame_in_done);
	assign op_col        = is_push ? in_col_q : out_col_q;
	assign col_ext       = ColW'(op_col) + ColW'(1);
	assign last_col      = (col_ext >= cols_q);
	// read ahead one column; the end of a row fetches column zero for the next row
	assign rd_addr       = last_col ? '0 : AddrW'(col_ext);

	always_comb begin
		op_new.emit      = is_push ? (in_row_q != '0) : 1'b1;
		op_new.write     = is_push;
		op_new.has_up    = is_push ? (in_row_q > RowW'(1)) : (out_row_q != '0);
		op_new.has_left  = (op_col != '0);
		op_new.has_right = !last_col;
		op_new.eof       = !is_push && last_col;
		op_new.col       = op_col;
		op_new.x_in      = request.grid_value;
		op_new.a_in      = request.accum_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (op_live) begin
			if (is_push) begin
				if (last_col) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + RowW'(1);
					out_row_q <= in_row_q;
					out_col_q <= '0;
				end else begin
					in_col_q  <= in_col_q + AddrW'(1);
					out_row_q <= (in_row_q != '0) ? in_row_q - RowW'(1) : '0;
					out_col_q <= in_col_q + AddrW'(1);
				end
			end else if (last_col) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				out_col_q <= out_col_q + AddrW'(1);
			end
		end
	end

	// handshake chain from the output register back to the request side
	assign rdy_o         = !result_valid_q || result_ready;
	assign rdy3          = !v3_q || rdy_o;
	assign rdy2          = !v2_q || rdy3;
	assign s1_go         = v1_q && (!op_s1.emit || rdy2);
	assign request_ready = !v1_q || s1_go;

	// line store
	assign ram_we          = s1_go && op_s1.write;
	assign wr_entry.x_cur  = op_s1.x_in;
	assign wr_entry.x_prev = cur_q.x_cur;
	assign wr_entry.accum  = op_s1.a_in;

	lapsa_ram #(
		.WIDTH ($bits(line_entry_t)),
		.DEPTH (MAX_COLUMNS)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (op_s1.col),
		.wdata (wr_entry),
		.re    (op_live),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// a read issued in the same cycle as the write of that entry sees old data
	assign nxt_entry = fwd_s1 ? fwd_data_s1 : line_entry_t'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (request_ready) begin
			v1_q <= op_live;
			if (op_live) begin
				fwd_s1 <= ram_we && (op_s1.col == rd_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_live) begin
			op_s1       <= op_new;
			fwd_data_s1 <= wr_entry;
		end
		if (s1_go) begin
			cur_q  <= nxt_entry;
			left_q <= cur_q.x_cur;
		end
	end

	// deg*center minus present neighbours, one difference per neighbour
	assign lap_w = lap_term(cur_q.x_cur, cur_q.x_prev, op_s1.has_up)
		+ lap_term(cur_q.x_cur, op_s1.x_in, op_s1.write)
		+ lap_term(cur_q.x_cur, left_q, op_s1.has_left)
		+ lap_term(cur_q.x_cur, nxt_entry.x_cur, op_s1.has_right);

	assign prod_w = lap_s2 * scale_q;

	// floor shift back to q16.16, then saturate the difference
	assign sh_w   = prod_s3[PROD_W-1:FRAC_SH];
	assign diff_w = DIFF_W'(acc_s3) - DIFF_W'(sh_w);
	assign sat_hi = !diff_w[DIFF_W-1] && (diff_w[DIFF_W-2:DATA_W-1] != '0);
	assign sat_lo = diff_w[DIFF_W-1] && (~diff_w[DIFF_W-2:DATA_W-1] != '0);

	always_comb begin
		res_w.end_of_frame = eof_s3;
		res_w.saturated    = sat_hi || sat_lo;
		if (sat_hi) begin
			res_w.result_value = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sat_lo) begin
			res_w.result_value = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			res_w.result_value = diff_w[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q           <= 1'b0;
			v3_q           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (rdy2) begin
				v2_q <= s1_go && op_s1.emit;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (rdy_o) begin
				result_valid_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && op_s1.emit) begin
			lap_s2 <= lap_w;
			acc_s2 <= cur_q.accum;
			eof_s2 <= op_s1.eof;
		end
		if (v2_q && rdy3) begin
			prod_s3 <= prod_w;
			acc_s3  <= acc_s2;
			eof_s3  <= eof_s2;
		end
		if (v3_q && rdy_o) begin
			result_q <= res_w;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_ALWAYS(a_out_row_behind, out_row_q <= in_row_q)
	`ASSERT_NEXT(a_frame_end_clears, op_live && !is_push && last_col, (in_row_q == '0) && (out_col_q == '0))
	`ASSERT_NEXT(a_fwd_on_collision, op_live && ram_we && (op_s1.col == rd_addr), fwd_s1)

endmodule

/* test/laplacian_stencil_accumulate_top_test.sv */
// testbench of the streaming five-point laplacian accumulator with its own line-store predictor
`timescale 1ns / 1ps
module laplacian_stencil_accumulate_top_test;
	import lapsa_pkg::*;

	localparam int unsigned MAX_COL      = MAX_COLUMNS_DEF;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned RANDOM_ITEMS = 1200;
	localparam int unsigned STEADY_ITEMS = 150;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic signed [DATA_W-1:0] WORD_HIGH = 32'sh7FFFFFFF;
	localparam logic signed [DATA_W-1:0] WORD_LOW  = 32'sh80000000;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   request_valid = 1'b0;
	logic                   request_ready;
	request_t               request = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                result;

	// predictor copy of the registers, line stores and raster counters
	logic [GEOM_W-1:0]          rows_reg = 11'd2;
	logic [GEOM_W-1:0]          cols_reg = 11'd2;
	logic signed [SCALE_W-1:0]  scale_reg = SCALE_RESET;
	logic signed [DATA_W-1:0]   grid_lines [2][MAX_COL];
	logic signed [DATA_W-1:0]   accum_line [MAX_COL];
	int unsigned                push_row = 0;
	int unsigned                push_col = 0;
	int unsigned                drain_row = 0;
	int unsigned                drain_col = 0;

	result_t     pending_updates [$];
	result_t     oldest_update;
	int unsigned error_count = 0;
	int unsigned live_items = 0;
	int unsigned cycle_count = 0;
	int unsigned receiver_hold = 0;
	bit          idle_enable = 1'b1;

	laplacian_stencil_accumulate_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.request_valid(request_valid),
		.request_ready(request_ready),
		.request      (request),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned clamp_geometry(logic [GEOM_W-1:0] word, int unsigned most);
		if (word < MIN_GEOM) return MIN_GEOM;
		if (word > most) return most;
		return word;
	endfunction

	function automatic int unsigned frame_rows();
		return clamp_geometry(rows_reg, MAX_ROWS_DEF);
	endfunction

	function automatic int unsigned frame_cols();
		return clamp_geometry(cols_reg, MAX_COL);
	endfunction

	function automatic int unsigned frame_elements_left();
		if (push_row >= frame_rows()) return 0;
		return frame_rows() * frame_cols() - (push_row * frame_cols() + push_col);
	endfunction

	function automatic longint line_value(int unsigned row, int unsigned col);
		if (col >= MAX_COL) return 0;
		return longint'(grid_lines[row % 2][col]);
	endfunction

	// a - floor(scale * (deg*x - neighbours) / 256), clamped to the word range
	function automatic result_t accumulate_update(longint acc, longint center, int deg,
			longint nsum, bit last);
		longint  prod;
		longint  sum;
		result_t res;
		prod = (deg * center - nsum) * longint'(scale_reg);
		sum = acc - (prod >>> FRAC_SH);
		res.saturated = 1'b0;
		if (sum > longint'(WORD_HIGH)) begin
			sum = longint'(WORD_HIGH);
			res.saturated = 1'b1;
		end else if (sum < longint'(WORD_LOW)) begin
			sum = longint'(WORD_LOW);
			res.saturated = 1'b1;
		end
		res.result_value = sum[DATA_W-1:0];
		res.end_of_frame = last;
		return res;
	endfunction

	// returns 1 when the request changes state, queues the update it causes
	function automatic bit predict_stencil_update(request_t req);
		int unsigned rows;
		int unsigned cols;
		int unsigned c;
		int unsigned pr;
		longint      center;
		longint      nsum;
		int          deg;
		rows = frame_rows();
		cols = frame_cols();
		nsum = 0;
		deg = 0;
		if (req.opcode == OP_PUSH) begin
			if (push_row >= rows) return 0;
			c = (push_col >= MAX_COL) ? MAX_COL - 1 : push_col;
			if (push_row >= 1) begin
				pr = push_row - 1;
				center = line_value(pr, c);
				// same parity slot still holds the row above pr
				if (pr > 0) begin
					nsum += line_value(push_row, c);
					deg++;
				end
				nsum += longint'(req.grid_value);
				deg++;
				if (c > 0) begin
					nsum += line_value(pr, c - 1);
					deg++;
				end
				if (c + 1 < cols) begin
					nsum += line_value(pr, c + 1);
					deg++;
				end
				pending_updates.push_back(accumulate_update(longint'(accum_line[c]), center,
					deg, nsum, 1'b0));
			end
			grid_lines[push_row % 2][c] = req.grid_value;
			accum_line[c] = req.accum_value;
			if (push_col + 1 >= cols) begin
				push_col = 0;
				push_row++;
			end else begin
				push_col++;
			end
			drain_row = (push_row >= 1) ? push_row - 1 : 0;
			drain_col = push_col;
			return 1;
		end
		if (push_row < rows) return 0;
		c = (drain_col >= MAX_COL) ? MAX_COL - 1 : drain_col;
		center = line_value(drain_row, c);
		if (drain_row > 0) begin
			nsum += line_value(drain_row + 1, c);
			deg++;
		end
		if (c > 0) begin
			nsum += line_value(drain_row, c - 1);
			deg++;
		end
		if (c + 1 < cols) begin
			nsum += line_value(drain_row, c + 1);
			deg++;
		end
		pending_updates.push_back(accumulate_update(longint'(accum_line[c]), center, deg,
			nsum, c + 1 >= cols));
		if (c + 1 >= cols) begin
			push_row = 0;
			push_col = 0;
			drain_row = 0;
			drain_col = 0;
		end else begin
			drain_col++;
		end
		return 1;
	endfunction

	function automatic logic signed [DATA_W-1:0] random_word();
		case ($urandom_range(0, 7))
			0: return WORD_HIGH;
			1: return WORD_LOW;
			2, 3: return $urandom();
			default: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_scale();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0100;
			3: return 16'($urandom());
			default: return 16'($urandom_range(0, 1023) - 512);
		endcase
	endfunction

	// geometry word, sometimes with junk above the register width
	function automatic logic [CFG_DATA_W-1:0] random_geometry(int unsigned most);
		logic [CFG_DATA_W-1:0] word;
		word = 16'($urandom_range(0, most));
		if ($urandom_range(0, 3) == 0) word[CFG_DATA_W-1:GEOM_W] = 5'($urandom());
		return word;
	endfunction

	task automatic wait_idle();
		request_valid <= 1'b0;
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_request(input opcode_t op, input logic signed [DATA_W-1:0] grid,
			input logic signed [DATA_W-1:0] accum);
		request_t req;
		req.opcode = op;
		req.grid_value = grid;
		req.accum_value = accum;
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			request_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		request_valid <= 1'b1;
		request <= req;
		@(posedge clk);
		while (!request_ready) @(posedge clk);
		if (predict_stencil_update(req)) live_items++;
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_ROW_COUNT) rows_reg = data[GEOM_W-1:0];
		else if (idx == REG_COLUMN_COUNT) cols_reg = data[GEOM_W-1:0];
		else if (idx == REG_SCALE) scale_reg = data;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] rows_word,
			input logic [CFG_DATA_W-1:0] cols_word, input logic [CFG_DATA_W-1:0] scale_word,
			input bit with_unused);
		wait_idle();
		write_register(REG_ROW_COUNT, rows_word);
		write_register(REG_COLUMN_COUNT, cols_word);
		write_register(REG_SCALE, scale_word);
		if (with_unused) write_register(REG_UNUSED, 16'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	// drains slipped in before a push are ignored since the frame is still open
	task automatic push_elements(input int unsigned count, input int unsigned noise_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_request(OP_DRAIN, random_word(), random_word());
			send_request(OP_PUSH, random_word(), random_word());
		end
	endtask

	task automatic drain_frame(input int unsigned noise_pct);
		while (push_row >= frame_rows()) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_request(OP_PUSH, random_word(), random_word());
			send_request(OP_DRAIN, random_word(), random_word());
		end
	endtask

	task automatic test_reset_defaults();
		send_request(OP_DRAIN, random_word(), random_word());
		push_elements(frame_elements_left(), 0);
		send_request(OP_PUSH, random_word(), random_word());
		drain_frame(0);
		send_request(OP_DRAIN, random_word(), random_word());
	endtask

	task automatic test_corner_cases();
		int unsigned r;
		int unsigned c;
		logic signed [DATA_W-1:0] grid;
		logic signed [DATA_W-1:0] accum;
		configure(16'd3, 16'd3, 16'h8000, 1'b1);
		for (r = 0; r < 3; r++) begin
			for (c = 0; c < 3; c++) begin
				// checkerboard of the extremes drives clamping both ways
				grid = ((r + c) % 2) ? WORD_LOW : WORD_HIGH;
				accum = (c == 1) ? '0 : ((r % 2) ? WORD_LOW : WORD_HIGH);
				send_request(OP_PUSH, grid, accum);
			end
		end
		send_request(OP_PUSH, random_word(), random_word());
		drain_frame(0);
	endtask

	task automatic test_geometry_mid_frame();
		configure(16'd4, 16'd5, random_scale(), 1'b0);
		push_elements(10, 0);
		// fewer columns from the next row on, more rows
		configure(16'd5, 16'd3, 16'h7FFF, 1'b0);
		push_elements(frame_elements_left(), 0);
		drain_frame(0);
		configure(16'd6, 16'd3, random_scale(), 1'b0);
		push_elements(9, 0);
		// row count below the rows already pushed closes the frame
		configure(16'd2, 16'd3, random_scale(), 1'b0);
		drain_frame(0);
	endtask

	task automatic test_extreme_geometry();
		configure({5'h1F, 11'h7FF}, 16'h0000, random_scale(), 1'b0);
		push_elements(frame_elements_left(), 5);
		drain_frame(5);
		configure(16'h0001, 16'd1024, random_scale(), 1'b0);
		push_elements(frame_elements_left(), 5);
		drain_frame(5);
	endtask

	task automatic test_output_stall();
		configure(16'd4, 16'd8, random_scale(), 1'b0);
		idle_enable = 1'b0;
		receiver_hold = 300;
		push_elements(frame_elements_left(), 0);
		drain_frame(0);
		wait_idle();
		idle_enable = 1'b1;
	endtask

	task automatic test_random_frames(input int unsigned quota);
		int unsigned target;
		target = live_items + quota;
		while (live_items < target) begin
			// half the frames follow on without a register update
			if ($urandom_range(0, 1))
				configure(random_geometry(8), random_geometry(12), random_scale(), 1'b0);
			push_elements(frame_elements_left(), 10);
			drain_frame(10);
		end
	endtask

	initial begin : result_receiver
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (receiver_hold != 0) begin
				stall_left = receiver_hold;
				receiver_hold = 0;
			end else if (stall_left == 0 && idle_enable && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			if (stall_left != 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_updates.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, result);
				error_count++;
			end else begin
				oldest_update = pending_updates.pop_front();
				if (result.result_value !== oldest_update.result_value) begin
					$display("%0t: result_value expected %h actual %h", $time,
						oldest_update.result_value, result.result_value);
					error_count++;
				end
				if (result.end_of_frame !== oldest_update.end_of_frame) begin
					$display("%0t: end_of_frame expected %b actual %b", $time,
						oldest_update.end_of_frame, result.end_of_frame);
					error_count++;
				end
				if (result.saturated !== oldest_update.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						oldest_update.saturated, result.saturated);
					error_count++;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_corner_cases();
		test_geometry_mid_frame();
		test_extreme_geometry();
		test_output_stall();
		test_random_frames(RANDOM_ITEMS);
		// closing stretch runs at full rate on both sides
		idle_enable = 1'b0;
		test_random_frames(STEADY_ITEMS);
		wait_idle();
		if (error_count == 0 && pending_updates.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/lapsa_pkg.sv
src/lapsa_ram.sv
src/laplacian_stencil_accumulate_top.sv
test/laplacian_stencil_accumulate_top_test.sv
